// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion wrappers for the nibble writer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, masked during reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that must hold at every clock edge, including during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/clcd_pkg.sv -----
// ----------------------------------------------------------------------------
// clcd_pkg
// Types, microcode ROM and power-up byte table for the LCD nibble writer.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

   localparam int DELAY_W     = 24;
   localparam int INIT_COUNT  = 9;
   localparam int IDX_W       = $clog2(INIT_COUNT);
   localparam int STEP_COUNT  = 4;
   localparam int STEP_W      = $clog2(STEP_COUNT);

   localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(4000000);
   localparam logic [1:0]         HOLD_ONE    = 2'd1;
   localparam logic [1:0]         HOLD_TWO    = 2'd2;
   localparam logic [IDX_W-1:0]   INIT_LAST   = IDX_W'(INIT_COUNT - 1);

   typedef enum logic [1:0] {
      OP_CMD  = 2'd0,
      OP_DATA = 2'd1,
      OP_INIT = 2'd2
   } op_type;

   typedef enum logic {
      NIB_HIGH = 1'b0,
      NIB_LOW  = 1'b1
   } nib_sel_type;

   // One control word per pin state of a byte.
   typedef struct packed {
      nib_sel_type nib_sel;
      logic        en;
      logic        tail;   // final state of a byte: loop or finish
   } ucode_word_type;

   localparam ucode_word_type UCODE_ROM [STEP_COUNT] = '{
      '{nib_sel: NIB_HIGH, en: 1'b1, tail: 1'b0},
      '{nib_sel: NIB_HIGH, en: 1'b0, tail: 1'b0},
      '{nib_sel: NIB_LOW,  en: 1'b1, tail: 1'b0},
      '{nib_sel: NIB_LOW,  en: 1'b0, tail: 1'b1}
   };

   localparam logic [7:0] INIT_BYTES [INIT_COUNT] = '{
      8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C
   };

   // Bytes whose final enable-low state is held two periods.
   localparam logic INIT_LONG [INIT_COUNT] = '{
      1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
   };

   // Sequencer to datapath control.
   typedef struct packed {
      logic             fire;
      nib_sel_type      nib_sel;
      logic             en;
      logic             hold_long;
      logic             last;
      logic             init;
      logic [IDX_W-1:0] idx;
   } seq_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/core/clcd_useq.sv -----
// ----------------------------------------------------------------------------
// clcd_useq
// Microcoded sequencer: step counter, control ROM and byte-loop jump.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_useq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                start_init,
   input  wire logic                advance,
   output      logic                busy,
   output      clcd_pkg::seq_ctrl_type ctrl
);
   import clcd_pkg::*;

`include "assert_macros.svh"

   logic             busy_ff, busy_in;
   logic             init_ff, init_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   ucode_word_type   word;
   logic             at_end;
   logic             fire;

   assign word   = UCODE_ROM[step_ff];
   assign at_end = !init_ff || (idx_ff == INIT_LAST);
   assign fire   = busy_ff && advance;

   always_comb begin
      ctrl.fire      = fire;
      ctrl.nib_sel   = word.nib_sel;
      ctrl.en        = word.en;
      ctrl.hold_long = word.tail && init_ff && INIT_LONG[idx_ff];
      ctrl.last      = word.tail && at_end;
      ctrl.init      = init_ff;
      ctrl.idx       = idx_ff;
   end

   always_comb begin
      busy_in = busy_ff;
      init_in = init_ff;
      step_in = step_ff;
      idx_in  = idx_ff;
      if (start) begin
         busy_in = 1'b1;
         init_in = start_init;
         step_in = '0;
         idx_in  = '0;
      end else if (fire) begin
         if (word.tail) begin
            step_in = '0;
            // loop to the next power-up byte, or finish
            if (at_end) begin
               busy_in = 1'b0;
               init_in = 1'b0;
               idx_in  = '0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         init_ff <= 1'b0;
         step_ff <= '0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         init_ff <= init_in;
         step_ff <= step_in;
         idx_ff  <= idx_in;
      end
   end

   assign busy = busy_ff;

   `ASSERT_CLK(a_last_ends_run, clock, reset, fire && ctrl.last |=> !busy_ff,
      "sequencer still busy after final pin state")
   `ASSERT_CLK(a_idle_step_zero, clock, reset,
      busy_ff || (step_ff == '0 && idx_ff == '0),
      "step or byte index left nonzero while idle")
   `ASSERT_CLK(a_idx_only_init, clock, reset, init_ff || idx_ff == '0,
      "byte index advanced outside power-up")

endmodule

`default_nettype wire

// ----- rtl/core/clcd_dp.sv -----
// ----------------------------------------------------------------------------
// clcd_dp
// Datapath: byte and select latch, nibble select, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire logic                   load_rs,
   input  wire logic [7:0]             load_byte,
   input  wire clcd_pkg::seq_ctrl_type ctrl,
   output      logic                   advance,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [7:0]             rsp_tdata,
   output      logic                   rsp_tuser,
   output      logic                   rsp_tlast
);
   import clcd_pkg::*;

`include "assert_macros.svh"

   logic [7:0] cur_byte_ff, cur_byte_in;
   logic       rs_ff, rs_in;
   logic [7:0] src_byte;
   logic [3:0] nibble;
   logic       valid_ff, valid_in;
   logic [3:0] nib_ff;
   logic       en_ff;
   logic [1:0] hold_ff;
   logic       last_ff;
   logic       sel_ff;

   always_comb begin
      cur_byte_in = cur_byte_ff;
      rs_in       = rs_ff;
      if (load) begin
         cur_byte_in = load_byte;
         rs_in       = load_rs;
      end
   end

   always_ff @(posedge clock) begin
      cur_byte_ff <= cur_byte_in;
      rs_ff       <= rs_in;
   end

   assign src_byte = ctrl.init ? INIT_BYTES[ctrl.idx] : cur_byte_ff;

   always_comb begin
      case (ctrl.nib_sel)
         NIB_HIGH: nibble = src_byte[7:4];
         NIB_LOW:  nibble = src_byte[3:0];
         default:  nibble = src_byte[3:0];
      endcase
   end

   // result register frees when empty or being taken
   assign advance  = !valid_ff || rsp_tready;
   assign valid_in = ctrl.fire || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.fire) begin
         sel_ff  <= rs_ff && !ctrl.init;
         nib_ff  <= nibble;
         en_ff   <= ctrl.en;
         hold_ff <= ctrl.hold_long ? HOLD_TWO : HOLD_ONE;
         last_ff <= ctrl.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, hold_ff, en_ff, nib_ff};
   assign rsp_tuser  = sel_ff;
   assign rsp_tlast  = last_ff;

   `ASSERT_CLK(a_fire_fills, clock, reset, ctrl.fire |=> valid_ff,
      "pin state lost: result register not filled")

endmodule

`default_nettype wire

// ----- rtl/core/char_lcd_nibble_writer_top.sv -----
// Each pin state of a request is registered in the result register as it frees.
// Throughput: one pin state per cycle while rsp_tready is high; a new request is
//   taken only when the sequencer is idle.
// Unused operation codes are taken and dropped with no result.
// Reset (synchronous, active high) idles the sequencer, empties the result
//   register and sets the delay register delay_ff to 4000000.
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_top
// Character LCD 4-bit bus writer: bytes and power-up sequence to pin states.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_writer_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output      logic                         req_tready,
   input  wire logic [7:0]                   req_tdata,  // [7:0] byte_value
   input  wire logic [1:0]                   req_tuser,  // [1:0] operation
   output      logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   output      logic [7:0]                   rsp_tdata,  // [3:0] data_nibble,
                                                         // [4] enable,
                                                         // [6:5] hold_periods,
                                                         // [7] zero
   output      logic                         rsp_tuser,  // [0] reg_select
   output      logic                         rsp_tlast,
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic [clcd_pkg::DELAY_W-1:0] csr_wdata
);
   import clcd_pkg::*;

   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic               accept;
   logic               start;
   logic               start_init;
   logic               busy;
   logic               advance;
   seq_ctrl_type       ctrl;

   assign csr_ready = 1'b1;
   assign delay_in  = (csr_valid && csr_ready) ? csr_wdata : delay_ff;

   // hold period length; pin results do not depend on it
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
      end else begin
         delay_ff <= delay_in;
      end
   end

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      start      = 1'b0;
      start_init = 1'b0;
      case (req_tuser)
         OP_CMD, OP_DATA: start = accept;
         OP_INIT: begin
            start      = accept;
            start_init = 1'b1;
         end
         default: start = 1'b0;
      endcase
   end

   clcd_useq u_useq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_init (start_init),
      .advance    (advance),
      .busy       (busy),
      .ctrl       (ctrl)
   );

   clcd_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .load       (start),
      .load_rs    (req_tuser == OP_DATA),
      .load_byte  (req_tdata),
      .ctrl       (ctrl),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Character LCD nibble writer testbench
// Sends command, data, power-up and unused requests through the request
// stream. A scoreboard predicts every pin state and checks each response
// field against it. Random idling on both streams and several delay settings
// written between phases.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import clcd_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         IDLE_PCT    = 19;
   localparam int         SETTLE_CYC  = 40;
   localparam int         CYCLE_LIMIT = 300000;
   localparam int         PHASE_ITEMS = 99;
   localparam int         INIT_STATES = 36;
   localparam logic [7:0] POWER_UP_BYTES [9] = '{
      8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C
   };

   typedef struct packed {
      logic       reg_select;
      logic [3:0] data_nibble;
      logic       enable;
      logic [1:0] hold_periods;
      logic       is_last;
   } pin_state_type;

   class lcd_pin_scoreboard;
      pin_state_type     pending_pins[$];
      logic [DELAY_W-1:0] delay_ticks;
      logic              sel_level;
      logic [3:0]        nibble_level;
      logic              enable_level;
      logic [5:0]        init_step;
      int                errors;
      int                checked;

      function new();
         delay_ticks  = DELAY_RESET;
         sel_level    = 1'b0;
         nibble_level = 4'd0;
         enable_level = 1'b0;
         init_step    = 6'd0;
         errors       = 0;
         checked      = 0;
      endfunction

      function int pending();
         return pending_pins.size();
      endfunction

      function void note_delay(logic [DELAY_W-1:0] ticks);
         delay_ticks = ticks;
      endfunction

      function void push_pins(logic [1:0] hold, logic is_last);
         pin_state_type s;
         s.reg_select   = sel_level;
         s.data_nibble  = nibble_level;
         s.enable       = enable_level;
         s.hold_periods = hold;
         s.is_last      = is_last;
         pending_pins.push_back(s);
      endfunction

      // High nibble strobe, then low nibble strobe.
      function void push_byte(logic rs, logic [7:0] b, logic [1:0] final_hold,
                              logic final_last);
         sel_level    = rs;
         nibble_level = b[7:4];
         enable_level = 1'b1;
         push_pins(HOLD_ONE, 1'b0);
         enable_level = 1'b0;
         push_pins(HOLD_ONE, 1'b0);
         nibble_level = b[3:0];
         enable_level = 1'b1;
         push_pins(HOLD_ONE, 1'b0);
         enable_level = 1'b0;
         push_pins(final_hold, final_last);
      endfunction

      function void note_request(logic [1:0] op, logic [7:0] b);
         int  idx;
         logic final_byte;
         case (op)
            OP_CMD, OP_DATA: begin
               push_byte(op[0], b, HOLD_ONE, 1'b1);
            end
            OP_INIT: begin
               for (init_step = 6'd0; init_step < INIT_STATES; init_step += 6'd4) begin
                  idx        = init_step / 4;
                  final_byte = (idx == 8);
                  push_byte(1'b0, POWER_UP_BYTES[idx],
                            (idx < 3 || final_byte) ? HOLD_TWO : HOLD_ONE, final_byte);
               end
               init_step = 6'd0;
            end
            default: ;  // unused operation: drop
         endcase
      endfunction

      task report_mismatch(string what);
         $display("[%0t] MISMATCH: %s", $realtime, what);
         errors++;
      endtask

      task check_pin_state(logic rs, logic [7:0] data, logic is_last);
         pin_state_type want;
         if (pending_pins.size() == 0) begin
            report_mismatch($sformatf("pin state rs=%0b data=%h last=%0b with no request pending",
                                      rs, data, is_last));
            return;
         end
         want = pending_pins.pop_front();
         checked++;
         if (rs !== want.reg_select)
            report_mismatch($sformatf("reg_select %0b, want %0b", rs, want.reg_select));
         if (data[3:0] !== want.data_nibble)
            report_mismatch($sformatf("data_nibble %h, want %h", data[3:0], want.data_nibble));
         if (data[4] !== want.enable)
            report_mismatch($sformatf("enable %0b, want %0b", data[4], want.enable));
         if (data[6:5] !== want.hold_periods)
            report_mismatch($sformatf("hold_periods %0d, want %0d", data[6:5],
                                      want.hold_periods));
         if (data[7] !== 1'b0)
            report_mismatch("padding bit of response data set");
         if (is_last !== want.is_last)
            report_mismatch($sformatf("last %0b, want %0b", is_last, want.is_last));
      endtask
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = 8'd0;
   logic [1:0]         req_tuser  = 2'd0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;
   logic               rsp_tuser;
   logic               rsp_tlast;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [DELAY_W-1:0] csr_wdata  = '0;

   lcd_pin_scoreboard board;
   bit                steady = 1'b0;
   int                cycle_count = 0;
   int                op_count [4] = '{0, 0, 0, 0};
   int                delay_writes = 0;

   char_lcd_nibble_writer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d pin states still pending",
                  cycle_count, board.pending());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Check accepted pin states; stall the response stream at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_pin_state(rsp_tuser, rsp_tdata, rsp_tlast);
      rsp_tready <= !reset && (steady || $urandom_range(99) >= IDLE_PCT);
   end

   task send_request(logic [1:0] op, logic [7:0] b);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      board.note_request(op, b);
      op_count[op]++;
   endtask

   // Wait out every pending pin state, then let a dropped request clear.
   task drain;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task write_delay(logic [DELAY_W-1:0] ticks);
      csr_valid <= 1'b1;
      csr_wdata <= ticks;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.note_delay(ticks);
      delay_writes++;
   endtask

   task random_phase;
      int         counted;
      int         pick;
      logic [1:0] op;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 42)
            op = OP_CMD;
         else if (pick < 84)
            op = OP_DATA;
         else if (pick < 94)
            op = OP_INIT;
         else
            op = OP_UNUSED;
         send_request(op, 8'($urandom));
         counted++;
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      logic [DELAY_W-1:0] phase_delay [4];
      board = new();
      phase_delay = '{24'hFFFFFF, 24'd0, DELAY_RESET, DELAY_W'($urandom_range(2, 24'hFFFFFE))};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_delay(24'd1);
      send_request(OP_CMD, 8'h00);
      send_request(OP_CMD, 8'hFF);
      send_request(OP_DATA, 8'h00);
      send_request(OP_DATA, 8'hFF);
      send_request(OP_DATA, 8'hA5);
      send_request(OP_CMD, 8'h5A);
      send_request(OP_INIT, 8'h00);
      send_request(OP_UNUSED, 8'hFF);
      send_request(OP_UNUSED, 8'h00);
      send_request(OP_INIT, 8'hFF);
      send_request(OP_DATA, 8'h0F);
      send_request(OP_CMD, 8'hF0);
      send_request(OP_INIT, 8'h5A);
      send_request(OP_DATA, 8'h80);
      send_request(OP_CMD, 8'h01);
      req_tvalid <= 1'b0;

      for (int p = 0; p < 4; p++) begin
         drain();
         write_delay(phase_delay[p]);
         // Keep both streams free of random idling for one whole phase.
         steady = (p == 2);
         random_phase();
      end
      steady = 1'b0;
      drain();

      $display("Sent %0d command, %0d data, %0d power-up and %0d unused requests",
               op_count[OP_CMD], op_count[OP_DATA], op_count[OP_INIT], op_count[OP_UNUSED]);
      $display("Checked %0d pin states across %0d delay register writes",
               board.checked, delay_writes);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", board.errors);
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// ----- char_lcd_nibble_writer_top.f -----
+incdir+rtl/core
rtl/core/clcd_pkg.sv
rtl/core/clcd_useq.sv
rtl/core/clcd_dp.sv
rtl/core/char_lcd_nibble_writer_top.sv
dv/testbench.sv
